### sv/lps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, request codes and the letter-to-level function of the light pattern sequencer.
package lps_pkg;

   localparam int NUM_STYLES  = 32;
   localparam int MAX_PATTERN = 64;
   localparam int TICK_MS     = 50;

   // Field widths fixed by the interface.
   localparam int TYPE_W   = 2;
   localparam int STYLE_W  = 5;
   localparam int CHAN_W   = 2;
   localparam int POSF_W   = 6;
   localparam int LETTER_W = 8;
   localparam int PLEN_W   = 6;
   localparam int TIME_W   = 31;
   localparam int LEVEL_W  = 8;

   // Derived sizes.
   localparam int RESULT_CAP  = 32;
   localparam int STYLE_COUNT = (NUM_STYLES > RESULT_CAP) ? RESULT_CAP : NUM_STYLES;
   localparam int SIDX_W      = (NUM_STYLES > 1) ? $clog2(NUM_STYLES) : 1;
   localparam int POS_W       = $clog2(MAX_PATTERN);
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int DIV_W       = LEN_W;
   localparam int DCNT_W      = $clog2(TIME_W);
   localparam int ROW_W       = SIDX_W + POS_W;
   localparam int ROWS        = NUM_STYLES * (2 ** POS_W);
   localparam int LANES       = 3;
   localparam int ROW_BITS    = LANES * LEVEL_W;

   // Reciprocal of the tick period, rounded up. With the shift below, (t * TICK_RECIP) >> TICK_SH
   // equals t / TICK_MS for every time that fits in TIME_W bits.
   localparam int TICK_SH = TIME_W + $clog2(TICK_MS);
   localparam int RECIP_W = TIME_W + 1;
   localparam int PROD_W  = TIME_W + RECIP_W;
   localparam logic [RECIP_W-1:0] TICK_RECIP =
      RECIP_W'(((64'd1 << TICK_SH) + 64'(TICK_MS - 1)) / 64'(TICK_MS));

   localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 8'd255;
   localparam logic [LETTER_W-1:0] LETTER_BASE = 8'd97;
   localparam logic [LETTER_W-1:0] LETTER_SPAN = 8'd25;

   typedef logic [TYPE_W-1:0] req_code_type;

   localparam req_code_type REQ_CLEAR  = 2'd0;
   localparam req_code_type REQ_WRITE  = 2'd1;
   localparam req_code_type REQ_LENGTH = 2'd2;
   localparam req_code_type REQ_TICK   = 2'd3;

   // Level is floor(51*d/5) = 10*d + floor(d/5); for d below 25, floor(d/5) = (13*d) >> 6.
   function automatic logic [LEVEL_W-1:0] letter_level(input logic [LETTER_W-1:0] c);
      logic [LETTER_W-1:0] d;
      logic [4:0]          d5;
      logic [9:0]          prod;
      begin
         d    = c - LETTER_BASE;
         d5   = d[4:0];
         prod = 10'(d5) * 10'd13;
         if (c <= LETTER_BASE) begin
            letter_level = '0;
         end else if (d >= LETTER_SPAN) begin
            letter_level = FULL_LEVEL;
         end else begin
            letter_level = 8'(8'(d5) * 8'd10 + 8'(prod >> 6));
         end
      end
   endfunction

endpackage

### sv/light_pattern_sequencer.sv
`timescale 1ns / 1ps
// Top level of the light pattern sequencer: pattern memory, length table and tick sequencer.
//
// A word is taken when start is high and busy is low. Write and length words leave busy low,
// so they may follow each other on every cycle. A clear word, and reset itself, start a
// clearing pass that sweeps the pattern memory one row per cycle through all 2048 rows, during
// which busy is high. A tick word first divides the time by the tick period with a single
// reciprocal multiplication, then walks the 32 styles in order. A style with a zero length is
// answered with full white straight from the length check; any other style takes the step
// modulo its length in a one-bit-per-cycle restoring divider, reads its row from the pattern
// memory and registers the result. Each result word appears on the rsp_ ports for exactly one
// cycle with rsp_valid high; the receiver cannot stall it, so it must take every strobe. The
// final style of a tick carries rsp_last_style, and busy drops on that same cycle.
module light_pattern_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lps_pkg::TYPE_W-1:0]     req_type,
   input  logic [lps_pkg::STYLE_W-1:0]    req_style,
   input  logic [lps_pkg::CHAN_W-1:0]     req_channel,
   input  logic [lps_pkg::POSF_W-1:0]     req_position,
   input  logic [lps_pkg::LETTER_W-1:0]   req_letter,
   input  logic [lps_pkg::PLEN_W-1:0]     req_pattern_len,
   input  logic [lps_pkg::TIME_W-1:0]     req_time_ms,
   output logic                           rsp_valid,
   output logic [lps_pkg::STYLE_W-1:0]    rsp_style_out,
   output logic [lps_pkg::LEVEL_W-1:0]    rsp_red,
   output logic [lps_pkg::LEVEL_W-1:0]    rsp_green,
   output logic [lps_pkg::LEVEL_W-1:0]    rsp_blue,
   output logic                           rsp_last_style
);
   import lps_pkg::*;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_TDIV  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_MDIV  = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
   localparam logic [SIDX_W-1:0] LAST_STYLE = SIDX_W'(STYLE_COUNT - 1);
   localparam logic [DCNT_W-1:0] LAST_BIT   = DCNT_W'(TIME_W - 1);

   logic [2:0]          state_ff, state_in;
   logic [ROW_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [SIDX_W-1:0]   sidx_ff, sidx_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [TIME_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [TIME_W-1:0]   step_ff, step_in;
   logic [LEN_W-1:0]    lens_ff [NUM_STYLES];
   logic [LEN_W-1:0]    lens_in [NUM_STYLES];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STYLE_W-1:0]  rsp_style_ff, rsp_style_in;
   logic [LEVEL_W-1:0]  rsp_red_ff, rsp_red_in;
   logic [LEVEL_W-1:0]  rsp_green_ff, rsp_green_in;
   logic [LEVEL_W-1:0]  rsp_blue_ff, rsp_blue_in;
   logic                rsp_last_ff, rsp_last_in;

   // Pattern memory: one row per style and step, three byte lanes (red, green, blue).
   logic [ROW_BITS-1:0] pat_mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic [LANES-1:0]    mem_we;
   logic [ROW_W-1:0]    mem_waddr;
   logic [ROW_BITS-1:0] mem_wdata;
   logic [ROW_W-1:0]    mem_raddr;

   logic                accept;
   logic [POS_W-1:0]    req_pos_w;
   logic [SIDX_W-1:0]   req_sidx_w;
   logic                write_ok;
   logic [LEN_W-1:0]    sat_len;
   logic [LEN_W-1:0]    cur_len;
   logic [LEVEL_W-1:0]  wr_level;

   logic [DIV_W:0]      trial;
   logic                trial_ge;
   logic [DIV_W-1:0]    rem_step;
   logic [TIME_W-1:0]   dvd_step;

   logic [PROD_W-1:0]   tick_prod;
   logic [TIME_W-1:0]   tick_step;

   assign busy           = (state_ff != S_IDLE);
   assign accept         = start && !busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_style_out  = rsp_style_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_last_style = rsp_last_ff;

   assign req_pos_w  = POS_W'(req_position);
   assign req_sidx_w = SIDX_W'(req_style);
   assign write_ok   = (32'(req_style) < 32'(NUM_STYLES)) && (req_channel < CHAN_W'(LANES))
                       && (32'(req_position) < 32'(MAX_PATTERN));
   assign sat_len    = (32'(req_pattern_len) > 32'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                                 : LEN_W'(req_pattern_len);
   assign cur_len    = lens_ff[sidx_ff];
   assign wr_level   = letter_level(req_letter);

   // The step number is the time times the rounded-up reciprocal of the tick period, shifted
   // down; the rounding error never reaches the integer part for any 31-bit time.
   assign tick_prod = PROD_W'(dvd_ff) * PROD_W'(TICK_RECIP);
   assign tick_step = TIME_W'(tick_prod >> TICK_SH);

   // One restoring division step: shift the next dividend bit into the partial remainder.
   assign trial    = {rem_ff, dvd_ff[TIME_W-1]};
   assign trial_ge = (trial >= {1'b0, div_ff});
   assign rem_step = trial_ge ? DIV_W'(trial - {1'b0, div_ff}) : DIV_W'(trial);
   assign dvd_step = {dvd_ff[TIME_W-2:0], trial_ge};

   // The read address points at the step just found by the modulo.
   assign mem_raddr = {sidx_ff, POS_W'(rem_ff)};

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      sidx_in      = sidx_ff;
      dcnt_in      = dcnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      lens_in      = lens_ff;
      rsp_valid_in = 1'b0;
      rsp_style_in = rsp_style_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = '0;
      mem_waddr    = {req_sidx_w, req_pos_w};
      mem_wdata    = {LANES{wr_level}};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_CLEAR: begin
                     for (int i = 0; i < NUM_STYLES; i++) begin
                        lens_in[i] = '0;
                     end
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
                  REQ_WRITE: begin
                     for (int i = 0; i < LANES; i++) begin
                        mem_we[i] = write_ok && (req_channel == CHAN_W'(i));
                     end
                  end
                  REQ_LENGTH: begin
                     if (32'(req_style) < 32'(NUM_STYLES)) begin
                        lens_in[req_sidx_w] = sat_len;
                     end
                  end
                  REQ_TICK: begin
                     dvd_in   = req_time_ms;
                     state_in = S_TDIV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLEAR: begin
            mem_we     = '1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_ROW) begin
               state_in = S_IDLE;
            end
         end
         S_TDIV: begin
            step_in  = tick_step;
            sidx_in  = '0;
            state_in = S_LEN;
         end
         S_LEN: begin
            if (cur_len == '0) begin
               // An empty pattern shows full white.
               rsp_valid_in = 1'b1;
               rsp_style_in = STYLE_W'(sidx_ff);
               rsp_red_in   = FULL_LEVEL;
               rsp_green_in = FULL_LEVEL;
               rsp_blue_in  = FULL_LEVEL;
               rsp_last_in  = (sidx_ff == LAST_STYLE);
               sidx_in      = sidx_ff + 1'b1;
               state_in     = (sidx_ff == LAST_STYLE) ? S_IDLE : S_LEN;
            end else begin
               dvd_in   = step_ff;
               rem_in   = '0;
               div_in   = DIV_W'(cur_len);
               dcnt_in  = '0;
               state_in = S_MDIV;
            end
         end
         S_MDIV: begin
            dvd_in  = dvd_step;
            rem_in  = rem_step;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == LAST_BIT) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_style_in = STYLE_W'(sidx_ff);
            rsp_red_in   = rd_data_ff[0*LEVEL_W +: LEVEL_W];
            rsp_green_in = rd_data_ff[1*LEVEL_W +: LEVEL_W];
            rsp_blue_in  = rd_data_ff[2*LEVEL_W +: LEVEL_W];
            rsp_last_in  = (sidx_ff == LAST_STYLE);
            sidx_in      = sidx_ff + 1'b1;
            state_in     = (sidx_ff == LAST_STYLE) ? S_IDLE : S_LEN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STYLES; i++) begin
            lens_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         lens_ff      <= lens_in;
      end
   end

   always_ff @(posedge clock) begin
      sidx_ff      <= sidx_in;
      dcnt_ff      <= dcnt_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      step_ff      <= step_in;
      rsp_style_ff <= rsp_style_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Pattern memory with per-lane write enables and a registered read port.
   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (mem_we[i]) begin
            pat_mem[mem_waddr][i*LEVEL_W +: LEVEL_W] <= mem_wdata[i*LEVEL_W +: LEVEL_W];
         end
      end
      rd_data_ff <= pat_mem[mem_raddr];
   end

   // The final result of a tick hands control back at once.
   a_last_frees : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_style) |-> !busy)
      else $error("busy still high after the final style of a tick");

   // Words other than a tick never produce a result.
   a_no_stray_rsp : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type != REQ_TICK)) |=> !rsp_valid)
      else $error("result strobe after a non-tick word");

   // The modulo leaves a step index below the pattern length before the memory read.
   a_rem_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (rem_ff < div_ff))
      else $error("step index not below pattern length");

   // No result leaves while the memory is being cleared.
   a_quiet_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid)
      else $error("result strobe during the clearing pass");

endmodule
